// ===== hdl/lbem_pkg.sv =====
`default_nettype none

package lbem_pkg;

   localparam int PIX_W        = 24;
   localparam int CHAN_W       = 8;
   localparam int CSR_IW       = 3;
   localparam int CSR_DW       = 13;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int MAX_HEIGHT   = 4096;
   localparam int ROW_W        = 12;
   localparam int HK_W         = HEIGHT_REG_W + 1;

   localparam logic [CSR_IW-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_EDGE_BLUE    = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_EDGE_GREEN   = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_EDGE_RED     = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_EDGE_ALPHA   = 3'd5;

   localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 11'd256;
   localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 13'd256;
   localparam logic [CHAN_W-1:0]       RESET_BLUE   = 8'd0;
   localparam logic [CHAN_W-1:0]       RESET_GREEN  = 8'd0;
   localparam logic [CHAN_W-1:0]       RESET_RED    = 8'd255;
   localparam logic [CHAN_W-1:0]       RESET_ALPHA  = 8'd255;

   typedef logic [PIX_W-1:0] pix_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_alpha;
      logic              frame_end;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/lbem_if.sv =====
`default_nettype none

interface lbem_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] pix_blue;
   logic [7:0] pix_green;
   logic [7:0] pix_red;

   modport source (output valid, func, pix_blue, pix_green, pix_red, input ready);
   modport sink (input valid, func, pix_blue, pix_green, pix_red, output ready);
endinterface

interface lbem_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_blue;
   logic [7:0] out_green;
   logic [7:0] out_red;
   logic [7:0] out_alpha;
   logic       frame_end;

   modport source (output valid, out_blue, out_green, out_red, out_alpha, frame_end,
                   input ready);
   modport sink (input valid, out_blue, out_green, out_red, out_alpha, frame_end,
                 output ready);
endinterface

interface lbem_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [12:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/label_boundary_edge_marker.sv =====
// Four-neighbour boundary marker for a label image streamed in raster order, one item
// per clock when ready. A pixel is an edge if it differs from its up, left, right or down
// neighbour (borders replicate); edges come out as the programmed RGBA colour, all
// else as zero. Results lag the input by one row: row 0 gives no result, and after
// the last row the sender gives one drain item per column to flush the last row,
// whose final result carries frame_end. Drain items while pixels are expected are
// dropped without a result. Two line stores of MAX_WIDTH x 24 bits hold the last
// two rows; they are read one column ahead with a write bypass, so that back-to-back
// items need no wait. A two-entry result buffer lets input continue for one result
// while the output is stalled. Write configuration only while the block is idle.
`default_nettype none

module label_boundary_edge_marker
   import lbem_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   lbem_req_if.sink    req_ch,
   lbem_rsp_if.source  rsp_ch,
   lbem_csr_if.sink    csr_ch
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int KW = ((WW > WIDTH_REG_W) ? WW : WIDTH_REG_W) + 1;
   localparam logic [KW-1:0]   MAXW_K = KW'(MAX_WIDTH);
   localparam logic [CW-1:0]   LAST_ADDR = CW'(MAX_WIDTH - 1);
   localparam logic [HK_W-1:0] MAXH_K = HK_W'(MAX_HEIGHT);

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [CHAN_W-1:0]       blue_ff, green_ff, red_ff, alpha_ff;

   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             draining_ff, draining_in;
   pix_type          hold_ff, hold_in;

   pix_type          prev_mem [MAX_WIDTH];
   pix_type          upper_mem [MAX_WIDTH];
   pix_type          prev_c_ff, prev_r_ff, upper_ff;
   pix_type          byp_pix_ff, byp_old_ff;
   logic             byp_c_ff, byp_r_ff;
   logic [CW-1:0]    ra_c, ra_r;

   result_type       out_ff, skid_ff, res;
   logic             out_valid_ff, skid_valid_ff;

   logic [KW-1:0]    w_k, w_eff, col_k;
   logic [HK_W-1:0]  h_k, h_eff;
   logic             last_col, last_row, right_ok;
   logic             acc, wr, drain_step, res_valid, pop;
   pix_type          pix, cen, rgt, up_raw, up, left, right, down;
   logic             top, is_edge;

   // configuration
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         blue_ff   <= RESET_BLUE;
         green_ff  <= RESET_GREEN;
         red_ff    <= RESET_RED;
         alpha_ff  <= RESET_ALPHA;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_ch.data[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_ch.data[HEIGHT_REG_W-1:0];
            CSR_EDGE_BLUE:    blue_ff   <= csr_ch.data[CHAN_W-1:0];
            CSR_EDGE_GREEN:   green_ff  <= csr_ch.data[CHAN_W-1:0];
            CSR_EDGE_RED:     red_ff    <= csr_ch.data[CHAN_W-1:0];
            CSR_EDGE_ALPHA:   alpha_ff  <= csr_ch.data[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp frame size
   always_comb begin
      w_k = KW'(width_ff);
      if (w_k == '0)
         w_eff = KW'(1);
      else if (w_k > MAXW_K)
         w_eff = MAXW_K;
      else
         w_eff = w_k;
      h_k = HK_W'(height_ff);
      if (h_k == '0)
         h_eff = HK_W'(1);
      else if (h_k > MAXH_K)
         h_eff = MAXH_K;
      else
         h_eff = h_k;
   end

   assign col_k    = KW'(col_ff);
   assign last_col = (col_k + KW'(1)) >= w_eff;
   assign right_ok = (col_k + KW'(1)) < w_eff;
   assign last_row = (HK_W'(row_ff) + HK_W'(1)) >= h_eff;

   // handshake
   assign req_ch.ready = !skid_valid_ff;
   assign acc          = req_ch.valid && req_ch.ready;
   assign drain_step   = acc && draining_ff;
   assign wr           = acc && !draining_ff && !req_ch.func;
   assign res_valid    = drain_step || (wr && (row_ff != '0));
   assign pix          = {req_ch.pix_red, req_ch.pix_green, req_ch.pix_blue};

   // neighbours of the current column, with bypass of the last write
   assign cen    = byp_c_ff ? byp_pix_ff : prev_c_ff;
   assign rgt    = byp_r_ff ? byp_pix_ff : prev_r_ff;
   assign up_raw = byp_c_ff ? byp_old_ff : upper_ff;

   always_comb begin
      top     = draining_ff ? (row_ff == '0) : (row_ff == ROW_W'(1));
      up      = top ? cen : up_raw;
      left    = (col_ff == '0) ? cen : hold_ff;
      right   = right_ok ? rgt : cen;
      down    = draining_ff ? cen : pix;
      is_edge = (up != cen) || (left != cen) || (right != cen) || (down != cen);
      res.out_blue  = is_edge ? blue_ff  : '0;
      res.out_green = is_edge ? green_ff : '0;
      res.out_red   = is_edge ? red_ff   : '0;
      res.out_alpha = is_edge ? alpha_ff : '0;
      res.frame_end = draining_ff && last_col;
   end

   // frame position
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      draining_in = draining_ff;
      hold_in     = hold_ff;
      if (drain_step) begin
         hold_in = cen;
         if (last_col) begin
            draining_in = 1'b0;
            col_in      = '0;
            row_in      = '0;
         end else begin
            col_in = col_ff + CW'(1);
         end
      end else if (wr) begin
         hold_in = cen;
         if (last_col) begin
            col_in = '0;
            if (last_row)
               draining_in = 1'b1;
            else
               row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         draining_ff <= 1'b0;
         hold_ff     <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         draining_ff <= draining_in;
         hold_ff     <= hold_in;
      end
   end

   // line stores, read ahead at the next column
   assign ra_c = col_in;
   assign ra_r = (col_in == LAST_ADDR) ? '0 : col_in + CW'(1);

   always_ff @(posedge clock) begin
      if (wr) begin
         prev_mem[col_ff]  <= pix;
         upper_mem[col_ff] <= cen;
      end
      prev_c_ff  <= prev_mem[ra_c];
      prev_r_ff  <= prev_mem[ra_r];
      upper_ff   <= upper_mem[ra_c];
      byp_pix_ff <= pix;
      byp_old_ff <= cen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_c_ff <= 1'b0;
         byp_r_ff <= 1'b0;
      end else begin
         byp_c_ff <= wr && (col_ff == ra_c);
         byp_r_ff <= wr && (col_ff == ra_r);
      end
   end

   // result buffer: output register plus skid entry
   assign pop = out_valid_ff && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= res_valid;
         end else begin
            out_valid_ff <= res_valid;
         end
      end else if (res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_ff  <= skid_ff;
            skid_ff <= res;
         end else begin
            out_ff <= res;
         end
      end else if (res_valid) begin
         skid_ff <= res;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.out_blue  = out_ff.out_blue;
   assign rsp_ch.out_green = out_ff.out_green;
   assign rsp_ch.out_red   = out_ff.out_red;
   assign rsp_ch.out_alpha = out_ff.out_alpha;
   assign rsp_ch.frame_end = out_ff.frame_end;

endmodule

`default_nettype wire

// ===== hdl/lbem_checker.sv =====
`default_nettype none

module lbem_checker
   import lbem_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire result_type  rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result changed while stalled");

   a_ready_low_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("input blocked without a stalled result");

   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result appeared without an accepted item");

endmodule

bind label_boundary_edge_marker lbem_checker u_lbem_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  ({rsp_ch.out_blue, rsp_ch.out_green, rsp_ch.out_red,
                rsp_ch.out_alpha, rsp_ch.frame_end})
);

`default_nettype wire
